// File: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the serial frame receiver with checksum.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // frame delimiters and fixed body length
  localparam logic [7:0] StartByte = 8'h7E;
  localparam logic [7:0] EndByte   = 8'hEF;
  localparam logic [7:0] BodyLen   = 8'd6;

  // number of stored bytes per frame (six body bytes and two checksum bytes)
  localparam int unsigned NumFrameBytes = 8;
  localparam int unsigned FrameIdxW     = $clog2(NumFrameBytes);

  // receive phase: idle, then one phase per stored byte, then the end byte
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_VER   = 4'd1,
    PH_LEN   = 4'd2,
    PH_CMD   = 4'd3,
    PH_FB    = 4'd4,
    PH_DHI   = 4'd5,
    PH_DLO   = 4'd6,
    PH_CKHI  = 4'd7,
    PH_CKLO  = 4'd8,
    PH_END   = 4'd9
  } phase_e;

  // frame status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_END = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_e;

  typedef logic [7:0] byte_t;

endpackage

// File: sv/serial_frame_receiver_checksum_core.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_checksum_core
// Collects received serial bytes into a start-delimited frame, checks the end
// byte, the length field and the 16-bit checksum, and emits one result word
// per frame.
// ----------------------------------------------------------------------------
// Output: the result word is registered and valid in the cycle after the end byte is accepted.
// Throughput: one byte per cycle; the only back-pressure is an end byte that
// arrives while the previous result is still held and stalled in the output
// register.
// Reset: receive phase returns to idle, the checksum accumulator and the output
// valid clear; stored frame bytes are not reset.
module serial_frame_receiver_checksum_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  // frame result
  output logic        frame_valid_o,
  input  logic        frame_stall_i,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  version_byte_o,
  output logic [7:0]  length_byte_o,
  output logic [7:0]  command_code_o,
  output logic [7:0]  feedback_byte_o,
  output logic [15:0] data_word_o
);

  sfr_pkg::phase_e  phase_q, phase_d;
  sfr_pkg::byte_t   frame_q [sfr_pkg::NumFrameBytes];
  logic [15:0]      sum_q, sum_d;
  logic             rx_acc;
  logic             end_acc;
  logic             store_en;
  logic [sfr_pkg::FrameIdxW-1:0] store_idx;
  sfr_pkg::status_e status_d;

  logic             res_valid_q;
  sfr_pkg::status_e res_status_q;
  sfr_pkg::byte_t   res_ver_q, res_len_q, res_cmd_q, res_fb_q;
  logic [15:0]      res_data_q;

  // only an end byte needs room in the output register
  assign rx_stall_o = res_valid_q && frame_stall_i && (phase_q == sfr_pkg::PH_END);
  assign rx_acc     = rx_valid_i && !rx_stall_o;
  assign end_acc    = rx_acc && (phase_q == sfr_pkg::PH_END);

  // next phase, byte store control and checksum accumulation
  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    store_en  = 1'b0;
    store_idx = '0;
    if (rx_acc) begin
      case (phase_q)
        sfr_pkg::PH_VER, sfr_pkg::PH_LEN, sfr_pkg::PH_CMD,
        sfr_pkg::PH_FB, sfr_pkg::PH_DHI, sfr_pkg::PH_DLO: begin
          store_en  = 1'b1;
          store_idx = sfr_pkg::FrameIdxW'(phase_q - 4'd1);
          sum_d     = sum_q + {8'h00, rx_byte_i};
          phase_d   = sfr_pkg::phase_e'(phase_q + 4'd1);
        end
        sfr_pkg::PH_CKHI: begin
          // checksum high byte folds into the sum at weight 256
          store_en  = 1'b1;
          store_idx = sfr_pkg::FrameIdxW'(phase_q - 4'd1);
          sum_d     = sum_q + {rx_byte_i, 8'h00};
          phase_d   = sfr_pkg::PH_CKLO;
        end
        sfr_pkg::PH_CKLO: begin
          store_en  = 1'b1;
          store_idx = sfr_pkg::FrameIdxW'(phase_q - 4'd1);
          sum_d     = sum_q + {8'h00, rx_byte_i};
          phase_d   = sfr_pkg::PH_END;
        end
        sfr_pkg::PH_END: begin
          sum_d   = '0;
          phase_d = sfr_pkg::PH_IDLE;
        end
        default: begin
          // idle: wait for the start byte
          if (rx_byte_i == sfr_pkg::StartByte) begin
            sum_d   = '0;
            phase_d = sfr_pkg::PH_VER;
          end else begin
            phase_d = sfr_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  // frame status, end marker first, then length, then checksum
  always_comb begin
    if (rx_byte_i != sfr_pkg::EndByte) begin
      status_d = sfr_pkg::ST_BAD_END;
    end else if (frame_q[1] != sfr_pkg::BodyLen) begin
      status_d = sfr_pkg::ST_BAD_LEN;
    end else if (sum_q != 16'h0000) begin
      status_d = sfr_pkg::ST_BAD_SUM;
    end else begin
      status_d = sfr_pkg::ST_OK;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfr_pkg::PH_IDLE;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
    end
  end

  // stored frame bytes
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      frame_q[store_idx] <= rx_byte_i;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (end_acc) begin
      res_valid_q <= 1'b1;
    end else if (!frame_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      res_status_q <= status_d;
      res_ver_q    <= frame_q[0];
      res_len_q    <= frame_q[1];
      res_cmd_q    <= frame_q[2];
      res_fb_q     <= frame_q[3];
      res_data_q   <= {frame_q[4], frame_q[5]};
    end
  end

  assign frame_valid_o   = res_valid_q;
  assign frame_status_o  = res_status_q;
  assign version_byte_o  = res_ver_q;
  assign length_byte_o   = res_len_q;
  assign command_code_o  = res_cmd_q;
  assign feedback_byte_o = res_fb_q;
  assign data_word_o     = res_data_q;

  // an accepted end byte always produces a result word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_acc |=> res_valid_q)
    else $error("end byte accepted without a result word");

  // an end byte is never taken while a stalled result is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(end_acc && res_valid_q && frame_stall_i))
    else $error("result word overwritten while stalled");

  // an ok status implies a length field of six
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_status_q == sfr_pkg::ST_OK)) |-> (res_len_q == sfr_pkg::BodyLen))
    else $error("ok status with wrong length field");

endmodule

// File: sim/tb_serial_frame_receiver_checksum_core.sv
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver_checksum_core
// Feeds serial bytes into the frame receiver: a few hand-built frames first,
// then random frames, noise and broken frames. A scoreboard follows the
// receive phase, the stored bytes and the running sum, and compares every
// frame result with its expectation. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver_checksum_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned FrameWords = 1250;

  // one frame result as the block reports it
  typedef struct packed {
    sfr_pkg::status_e status;
    sfr_pkg::byte_t   version;
    sfr_pkg::byte_t   length;
    sfr_pkg::byte_t   command;
    sfr_pkg::byte_t   feedback;
    logic [15:0]      data;
  } frame_t;

  // tracks the receive phase and holds the frame results still to come
  class frame_scoreboard;
    sfr_pkg::phase_e phase;
    sfr_pkg::byte_t  stored[sfr_pkg::NumFrameBytes];
    logic [15:0]     body_sum;
    frame_t          expected_frames[$];
    int unsigned     mismatches;

    function new();
      phase      = sfr_pkg::PH_IDLE;
      body_sum   = '0;
      mismatches = 0;
      foreach (stored[i]) stored[i] = '0;
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    // advance the frame state by one accepted word
    function void note_byte(sfr_pkg::byte_t b);
      int          idx;
      logic [15:0] check_word;
      logic [15:0] total;
      frame_t      f;
      if (phase >= sfr_pkg::PH_VER && phase <= sfr_pkg::PH_CKLO) begin
        idx = int'(phase) - 1;
        stored[idx] = b;
        if (phase <= sfr_pkg::PH_DLO) body_sum = body_sum + 16'(b);
        phase = sfr_pkg::phase_e'(phase + 4'd1);
      end else if (phase == sfr_pkg::PH_END) begin
        check_word = {stored[6], stored[7]};
        total      = body_sum + check_word;
        if (b != sfr_pkg::EndByte) f.status = sfr_pkg::ST_BAD_END;
        else if (stored[1] != sfr_pkg::BodyLen) f.status = sfr_pkg::ST_BAD_LEN;
        else if (total != 16'd0) f.status = sfr_pkg::ST_BAD_SUM;
        else f.status = sfr_pkg::ST_OK;
        f.version  = stored[0];
        f.length   = stored[1];
        f.command  = stored[2];
        f.feedback = stored[3];
        f.data     = {stored[4], stored[5]};
        expected_frames.push_back(f);
        phase    = sfr_pkg::PH_IDLE;
        body_sum = '0;
      end else if (b == sfr_pkg::StartByte) begin
        body_sum = '0;
        phase    = sfr_pkg::PH_VER;
      end else begin
        phase = sfr_pkg::PH_IDLE;
      end
    endfunction

    task report(string field, int unsigned want, int unsigned got);
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      mismatches++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_frame(frame_t got);
      frame_t want;
      if (expected_frames.size() == 0) begin
        report("unexpected frame result, status", 0, got.status);
        return;
      end
      want = expected_frames.pop_front();
      if (got.status !== want.status) report("frame_status", want.status, got.status);
      if (got.version !== want.version) report("version_byte", want.version, got.version);
      if (got.length !== want.length) report("length_byte", want.length, got.length);
      if (got.command !== want.command) report("command_code", want.command, got.command);
      if (got.feedback !== want.feedback)
        report("feedback_byte", want.feedback, got.feedback);
      if (got.data !== want.data) report("data_word", want.data, got.data);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        rx_valid_i;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i;
  logic        frame_valid_o;
  logic        frame_stall_i;
  logic [1:0]  frame_status_o;
  logic [7:0]  version_byte_o;
  logic [7:0]  length_byte_o;
  logic [7:0]  command_code_o;
  logic [7:0]  feedback_byte_o;
  logic [15:0] data_word_o;

  frame_scoreboard sb;
  bit              steady = 1'b0;
  int unsigned     idle_cycles = 0;
  int unsigned     frame_words_sent = 0;

  serial_frame_receiver_checksum_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_valid_o   (frame_valid_o),
    .frame_stall_i   (frame_stall_i),
    .frame_status_o  (frame_status_o),
    .version_byte_o  (version_byte_o),
    .length_byte_o   (length_byte_o),
    .command_code_o  (command_code_o),
    .feedback_byte_o (feedback_byte_o),
    .data_word_o     (data_word_o)
  );

  always #5 clk_i = ~clk_i;

  // monitor both channels and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frame_valid_o && !frame_stall_i)
        sb.check_frame({sfr_pkg::status_e'(frame_status_o), version_byte_o, length_byte_o,
                        command_code_o, feedback_byte_o, data_word_o});
      if (rx_valid_i && !rx_stall_o) sb.note_byte(rx_byte_i);
      if ((frame_valid_o && !frame_stall_i) || (rx_valid_i && !rx_stall_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles", IdleLimit);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stall before each word, none in steady stretches
  initial begin
    int unsigned hold;
    frame_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = steady ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        frame_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        frame_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!(frame_valid_o && !frame_stall_i));
    end
  end

  // send one word; called and returns at a falling edge
  task automatic send_byte(input sfr_pkg::byte_t b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      rx_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!(rx_valid_i && !rx_stall_o));
    frame_words_sent += 1;
    @(negedge clk_i);
  endtask

  // full frame; checksum either right or deliberately off
  task automatic send_frame(input sfr_pkg::byte_t ver, input sfr_pkg::byte_t len,
                            input sfr_pkg::byte_t cmd, input sfr_pkg::byte_t fb,
                            input sfr_pkg::byte_t dhi, input sfr_pkg::byte_t dlo,
                            input bit sum_ok, input sfr_pkg::byte_t end_b);
    logic [15:0] sum;
    logic [15:0] ck;
    sum = 16'(ver) + 16'(len) + 16'(cmd) + 16'(fb) + 16'(dhi) + 16'(dlo);
    ck  = -sum;
    if (!sum_ok) ck = ck ^ 16'($urandom_range(1, 65535));
    send_byte(sfr_pkg::StartByte);
    send_byte(ver);
    send_byte(len);
    send_byte(cmd);
    send_byte(fb);
    send_byte(dhi);
    send_byte(dlo);
    send_byte(ck[15:8]);
    send_byte(ck[7:0]);
    send_byte(end_b);
  endtask

  // random byte leaning toward the delimiter values
  function automatic sfr_pkg::byte_t pick_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return sfr_pkg::StartByte;
    if (r == 1) return sfr_pkg::EndByte;
    return sfr_pkg::byte_t'($urandom);
  endfunction

  task automatic random_traffic();
    sfr_pkg::byte_t b;
    sfr_pkg::byte_t len;
    sfr_pkg::byte_t end_b;
    int unsigned    n;
    while (frame_words_sent < FrameWords) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      // idle noise that the receiver skips
      if ($urandom_range(0, 9) < 3) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          b = sfr_pkg::byte_t'($urandom);
          if (b == sfr_pkg::StartByte) b = sfr_pkg::EndByte;
          send_byte(b);
        end
      end
      // cut-off frame: the next start word lands in the body or on the end byte
      if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(0, 8);
        send_byte(sfr_pkg::StartByte);
        repeat (n) send_byte(pick_byte());
      end
      len   = ($urandom_range(0, 3) != 0) ? sfr_pkg::BodyLen : sfr_pkg::byte_t'($urandom);
      end_b = ($urandom_range(0, 6) != 0) ? sfr_pkg::EndByte : pick_byte();
      send_frame(pick_byte(), len, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                 $urandom_range(0, 9) < 7, end_b);
    end
  endtask

  initial begin
    sb         = new();
    rst_ni     = 1'b0;
    rx_valid_i = 1'b0;
    rx_byte_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: idle noise, good frame with extreme fields and a start word
    // inside the body, then a bad end word on a frame with a zero length
    send_byte(8'hFF);
    send_byte(sfr_pkg::EndByte);
    send_frame(8'hFF, sfr_pkg::BodyLen, sfr_pkg::StartByte, 8'h00, 8'hFF, 8'hFF, 1'b1,
               sfr_pkg::EndByte);
    send_frame(8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h00);

    random_traffic();

    // drain and let the last result settle
    rx_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
